FILE: hw/rtl/agc_pkg.sv
`default_nettype none

package agc_pkg;

  // field and register widths
  localparam int SAMPLE_W = 16;
  localparam int TARGET_W = 23;
  localparam int RATE_W   = 17;
  localparam int GAIN_W   = 23;
  localparam int LEVEL_W  = 30;
  localparam int MAG_W    = 17;
  localparam int CFG_IDX_W = 2;

  // register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 2'd2;

  // register reset values
  localparam logic [TARGET_W-1:0] TARGET_RESET = 23'd2097152;
  localparam logic [RATE_W-1:0]   ATTACK_RESET = 17'd6554;
  localparam logic [RATE_W-1:0]   DECAY_RESET  = 17'd66;

  // q7.16 gain limits and unity
  localparam logic [GAIN_W-1:0] GAIN_ONE = 23'd65536;
  localparam logic [GAIN_W-1:0] GAIN_MIN = 23'd655;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 23'd6553600;
  localparam logic [RATE_W-1:0] RATE_ONE = 17'd65536;

  // quotient is below 2^23 once the overflow pre-check passes
  localparam int DIV_STEPS = 23;
  localparam int CNT_W     = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_STEP,
    ST_EST,
    ST_DIV_INIT,
    ST_DIV,
    ST_GAIN,
    ST_OUT_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mag_mul;
    logic step_mul;
    logic est_upd;
    logic div_start;
    logic div_step;
    logic gain_max;
    logic gain_quot;
    logic out_mul;
    logic load_out;
  } agc_cmd_t;

  typedef struct packed {
    logic est_zero;
    logic div_ovf;
    logic div_last;
    logic out_free;
  } agc_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/agc_ctrl.sv
`default_nettype none

module agc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire agc_pkg::agc_stat_t stat,
  output agc_pkg::agc_cmd_t     cmd
);

  agc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= agc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      agc_pkg::ST_IDLE:     if (in_valid) state_next = agc_pkg::ST_MAG;
      agc_pkg::ST_MAG:      state_next = agc_pkg::ST_STEP;
      agc_pkg::ST_STEP:     state_next = agc_pkg::ST_EST;
      agc_pkg::ST_EST:      state_next = agc_pkg::ST_DIV_INIT;
      agc_pkg::ST_DIV_INIT: begin
        priority if (stat.est_zero) state_next = agc_pkg::ST_OUT_MUL;
        else if (stat.div_ovf)      state_next = agc_pkg::ST_OUT_MUL;
        else                        state_next = agc_pkg::ST_DIV;
      end
      agc_pkg::ST_DIV:      if (stat.div_last) state_next = agc_pkg::ST_GAIN;
      agc_pkg::ST_GAIN:     state_next = agc_pkg::ST_OUT_MUL;
      agc_pkg::ST_OUT_MUL:  state_next = agc_pkg::ST_EMIT;
      agc_pkg::ST_EMIT:     if (stat.out_free) state_next = agc_pkg::ST_IDLE;
      default:              state_next = agc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      agc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      agc_pkg::ST_MAG:      cmd.mag_mul  = 1'b1;
      agc_pkg::ST_STEP:     cmd.step_mul = 1'b1;
      agc_pkg::ST_EST:      cmd.est_upd  = 1'b1;
      agc_pkg::ST_DIV_INIT: begin
        cmd.div_start = !stat.est_zero && !stat.div_ovf;
        cmd.gain_max  = !stat.est_zero && stat.div_ovf;
      end
      agc_pkg::ST_DIV:      cmd.div_step  = 1'b1;
      agc_pkg::ST_GAIN:     cmd.gain_quot = 1'b1;
      agc_pkg::ST_OUT_MUL:  cmd.out_mul   = 1'b1;
      agc_pkg::ST_EMIT:     cmd.load_out  = stat.out_free;
      default:              cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/agc_datapath.sv
`default_nettype none

module agc_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [agc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [agc_pkg::TARGET_W-1:0]        cfg_data,
  input  wire logic [agc_pkg::SAMPLE_W-1:0]        sample_in,
  input  wire agc_pkg::agc_cmd_t                   cmd,
  output agc_pkg::agc_stat_t                       stat,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [agc_pkg::SAMPLE_W-1:0]             sample_out,
  output logic [agc_pkg::GAIN_W-1:0]               gain_now
);

  localparam int PROD_W = agc_pkg::MAG_W + agc_pkg::GAIN_W;
  localparam int STEP_W = agc_pkg::RATE_W + agc_pkg::LEVEL_W;

  logic [agc_pkg::TARGET_W-1:0] target_level;
  logic [agc_pkg::RATE_W-1:0]   attack_rate;
  logic [agc_pkg::RATE_W-1:0]   decay_rate;

  logic [agc_pkg::SAMPLE_W-1:0] sample_r;
  logic [agc_pkg::GAIN_W-1:0]   gain;
  logic [agc_pkg::LEVEL_W-1:0]  level;
  logic [agc_pkg::LEVEL_W-1:0]  est;
  logic [STEP_W-1:0]            step_prod;
  logic                         up;
  logic [agc_pkg::LEVEL_W-1:0]  rem;
  logic [agc_pkg::DIV_STEPS-1:0] dvd;
  logic [agc_pkg::DIV_STEPS-1:0] quot;
  logic [agc_pkg::CNT_W-1:0]    cnt;
  logic [PROD_W-1:0]            out_prod;

  logic                         neg;
  logic [agc_pkg::MAG_W-1:0]    mag;
  logic [PROD_W-1:0]            mag_prod;
  logic                         rise;
  logic [agc_pkg::LEVEL_W-1:0]  diff;
  logic [agc_pkg::RATE_W-1:0]   rate_sel;
  logic [agc_pkg::RATE_W-1:0]   rate_clamped;
  logic [agc_pkg::LEVEL_W-1:0]  step;
  logic [agc_pkg::LEVEL_W+1:0]  trial;
  logic                         trial_ge;
  logic [agc_pkg::LEVEL_W-1:0]  target_hi;
  logic [PROD_W-17:0]           omag;
  logic [agc_pkg::SAMPLE_W-1:0] sat_out;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= agc_pkg::TARGET_RESET;
      attack_rate  <= agc_pkg::ATTACK_RESET;
      decay_rate   <= agc_pkg::DECAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        agc_pkg::REG_TARGET: target_level <= cfg_data;
        agc_pkg::REG_ATTACK: attack_rate  <= cfg_data[agc_pkg::RATE_W-1:0];
        agc_pkg::REG_DECAY:  decay_rate   <= cfg_data[agc_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // sample magnitude, shared by the level and output multiplies
  assign neg = sample_r[agc_pkg::SAMPLE_W-1];
  assign mag = neg ? (agc_pkg::RATE_ONE - {1'b0, sample_r}) : {1'b0, sample_r};
  assign mag_prod = PROD_W'(mag) * PROD_W'(gain);

  // tracking step
  assign rise     = level > est;
  assign diff     = rise ? (level - est) : (est - level);
  assign rate_sel = rise ? attack_rate : decay_rate;
  assign rate_clamped = (rate_sel > agc_pkg::RATE_ONE) ? agc_pkg::RATE_ONE : rate_sel;
  assign step     = step_prod[agc_pkg::LEVEL_W+15:16];

  // restoring divider step
  assign trial    = {1'b0, rem, dvd[agc_pkg::DIV_STEPS-1]} - {2'b00, est};
  assign trial_ge = !trial[agc_pkg::LEVEL_W+1];
  assign target_hi = agc_pkg::LEVEL_W'(target_level[agc_pkg::TARGET_W-1:7]);

  assign stat.est_zero = (est == '0);
  assign stat.div_ovf  = (target_hi >= est);
  assign stat.div_last = (cnt == '0);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) sample_r <= sample_in;
    if (cmd.mag_mul) level <= mag_prod[agc_pkg::LEVEL_W+7:8];
    if (cmd.step_mul) begin
      step_prod <= STEP_W'(rate_clamped) * STEP_W'(diff);
      up        <= rise;
    end
    if (cmd.div_start) begin
      rem  <= target_hi;
      dvd  <= {target_level[6:0], 16'd0};
      quot <= '0;
      cnt  <= agc_pkg::CNT_W'(agc_pkg::DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? trial[agc_pkg::LEVEL_W-1:0]
                       : {rem[agc_pkg::LEVEL_W-2:0], dvd[agc_pkg::DIV_STEPS-1]};
      dvd  <= {dvd[agc_pkg::DIV_STEPS-2:0], 1'b0};
      quot <= {quot[agc_pkg::DIV_STEPS-2:0], trial_ge};
      cnt  <= cnt - agc_pkg::CNT_W'(1);
    end
    if (cmd.out_mul) out_prod <= mag_prod;
  end

  // loop state: estimate and gain
  always_ff @(posedge clk) begin
    if (rst) begin
      est  <= agc_pkg::LEVEL_W'(agc_pkg::TARGET_RESET);
      gain <= agc_pkg::GAIN_ONE;
    end else begin
      if (cmd.est_upd) est <= up ? (est + step) : (est - step);
      if (cmd.gain_max) begin
        gain <= agc_pkg::GAIN_MAX;
      end else if (cmd.gain_quot) begin
        priority if (quot < agc_pkg::GAIN_MIN) gain <= agc_pkg::GAIN_MIN;
        else if (quot > agc_pkg::GAIN_MAX)     gain <= agc_pkg::GAIN_MAX;
        else                                   gain <= quot;
      end
    end
  end

  // truncate toward zero and saturate
  assign omag = out_prod[PROD_W-1:16];
  always_comb begin
    if (neg) begin
      sat_out = (omag > 24'd32768) ? 16'h8000 : agc_pkg::SAMPLE_W'(-omag);
    end else begin
      sat_out = (omag > 24'd32767) ? 16'h7FFF : omag[agc_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample_out <= sat_out;
      gain_now   <= gain;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/automatic_gain_control.sv
`default_nettype none

// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata[15:0] sample_in
// m_axis    out  m_axis_tvalid/tready      tdata[15:0] sample_out, [38:16] gain_now
// cfg       in   cfg_we                    cfg_index, cfg_data
//
// a result is loaded after three multiply stages, an estimate update, a divider set-up
// and a 23-step restoring divider (one quotient bit a cycle); a new input beat is
// taken only once the previous result is loaded; a zero estimate or a gain that
// saturates high skips the divider
// synchronous reset loads gain 1.0, the estimate from the target reset value
// and the register reset values; no clearing pass
// a finished result waits in the output register while the next beat is
// taken; the datapath stalls only when that register is still full

module automatic_gain_control (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [15:0] sample_out, [38:16] gain_now, [39] zero
  // register writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [22:0] cfg_data
);

  agc_pkg::agc_cmd_t  cmd;
  agc_pkg::agc_stat_t stat;

  logic [agc_pkg::SAMPLE_W-1:0] sample_out;
  logic [agc_pkg::GAIN_W-1:0]   gain_now;

  // sequencer: walks one beat through multiply, track, divide, scale
  agc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, loop state, config registers and the output register
  agc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .sample_out (sample_out),
    .gain_now   (gain_now)
  );

  // pack fields lowest first, pad to whole bytes
  assign m_axis_tdata = {1'b0, gain_now, sample_out};

endmodule

`default_nettype wire
